// ===== src/small_cofactor_witness_search_unit_defines.svh =====
// Assertion macros shared by the small cofactor witness search unit.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef SMALL_COFACTOR_WITNESS_SEARCH_UNIT_DEFINES_SVH
`define SMALL_COFACTOR_WITNESS_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/scws_pkg.sv =====
// Package for the small cofactor witness search unit.
// Holds widths, register indexes and the sequencer state type; no dependencies.
`default_nettype none

package scws_pkg;

    localparam int K_LIMIT   = 32;
    localparam int R_W       = 32;
    localparam int HALF_W    = 31;
    localparam int K_W       = 6;
    localparam int M_W       = 5;
    localparam int VAL_W     = 37;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = 5;
    localparam int DIV_W     = DIV_BITS * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 48;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MULTIPLE   = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_DIV,
        ST_EVAL,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== src/small_cofactor_witness_search_unit.sv =====
// Top level of the small cofactor witness search unit.
// Uses scws_pkg and the assertion macros of small_cofactor_witness_search_unit_defines.svh.
// Sequencer around one shared radix-256 remainder and quotient unit.
`default_nettype none

`include "small_cofactor_witness_search_unit_defines.svh"

// One modulus is taken at a time. For each multiple and sign the sequencer sets up the
// value in ST_PAIR, then tries divisors from the divisor limit down to 2: for each one
// the shared divider runs in ST_DIV (eight quotient bits a cycle over a 40-bit dividend)
// and ST_EVAL judges the result. The scan of a value stops at the first divisor whose
// quotient passes. The result waits in an output register, and the next item is taken
// while it waits.
module small_cofactor_witness_search_unit
    import scws_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [K_W-1:0]         i_cfg_data,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [R_W-1:0]         s_axis_tdata,   // modulus
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // best_divisor, best_quotient, best_multiple, plus_sign, zero fill
    output logic [OUT_W-1:0]       m_axis_tdata,
    output logic                   m_axis_tuser    // found
);

    t_state               r_state, n_state;
    logic [K_W-1:0]       r_max_multiplier;
    logic [M_W-1:0]       r_max_multiple;
    logic [R_W-1:0]       r_r, n_r;
    logic [HALF_W-1:0]    r_half, n_half;
    logic [K_W-1:0]       r_klim, n_klim;
    logic [M_W:0]         r_m, n_m;
    logic [VAL_W-1:0]     r_mr, n_mr;
    logic                 r_sign, n_sign;
    logic [VAL_W-1:0]     r_value, n_value;
    logic [K_W-1:0]       r_k, n_k;
    logic [DIV_W-1:0]     r_dq, n_dq;
    logic [K_W-1:0]       r_rem, n_rem;
    logic [STEP_W-1:0]    r_step, n_step;
    logic                 r_found, n_found;
    logic [K_W-1:0]       r_bk, n_bk;
    logic [HALF_W-1:0]    r_bt, n_bt;
    logic [M_W-1:0]       r_bm, n_bm;
    logic                 r_bs, n_bs;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic                 r_out_user;

    logic                 in_accept;
    logic                 out_free;
    logic                 adv_sign;
    logic [M_W:0]         adv_m;
    logic [VAL_W-1:0]     adv_mr;
    logic [K_W-1:0]       d_rem;
    logic [DIV_W-1:0]     d_dq;
    logic                 pair_over;
    logic                 pair_skip;
    logic                 cand;
    logic                 better;
    logic [K_W-1:0]       sat_klim;

    // Shared divider: eight restoring steps on the narrow remainder per cycle.
    always_comb begin
        d_rem = r_rem;
        d_dq  = r_dq;
        for (int i = 0; i < DIV_BITS; i++) begin
            d_rem = {d_rem[K_W-2:0], d_dq[DIV_W-1]};
            d_dq  = {d_dq[DIV_W-2:0], 1'b0};
            if (d_rem >= r_k) begin
                d_rem   = d_rem - r_k;
                d_dq[0] = 1'b1;
            end
        end
    end

    always_comb begin
        adv_sign  = ~r_sign;
        adv_m     = r_sign ? r_m + (M_W+1)'(1) : r_m;
        adv_mr    = r_sign ? r_mr + VAL_W'(r_r) : r_mr;
        pair_over = r_m > {1'b0, r_max_multiple};
        pair_skip = (r_klim < K_W'(2)) || (!r_sign && (r_mr <= VAL_W'(1)));
        cand      = (r_rem == '0) && (r_dq <= DIV_W'(r_half));
        better    = !r_found || (r_dq[HALF_W-1:0] < r_bt)
                    || ((r_dq[HALF_W-1:0] == r_bt) && (r_k < r_bk));
        sat_klim  = (r_max_multiplier > K_W'(K_LIMIT)) ? K_W'(K_LIMIT) : r_max_multiplier;
    end

    // Handshake outputs.
    always_comb begin
        o_cfg_ready   = 1'b1;
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_data;
        m_axis_tuser  = r_out_user;
        in_accept     = s_axis_tvalid && s_axis_tready;
        out_free      = !r_out_valid || m_axis_tready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_PAIR;
            end
            ST_PAIR: begin
                if (pair_over) n_state = ST_FINISH;
                else if (!pair_skip) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (cand || (r_k == K_W'(2))) n_state = ST_PAIR;
                else n_state = ST_DIV;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_r     = r_r;
        n_half  = r_half;
        n_klim  = r_klim;
        n_m     = r_m;
        n_mr    = r_mr;
        n_sign  = r_sign;
        n_value = r_value;
        n_k     = r_k;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_step  = r_step;
        n_found = r_found;
        n_bk    = r_bk;
        n_bt    = r_bt;
        n_bm    = r_bm;
        n_bs    = r_bs;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_r     = s_axis_tdata;
                    n_half  = s_axis_tdata[R_W-1:1];
                    n_klim  = sat_klim;
                    n_m     = (M_W+1)'(1);
                    n_mr    = VAL_W'(s_axis_tdata);
                    n_sign  = 1'b0;
                    n_found = 1'b0;
                    n_bk    = '0;
                    n_bt    = '0;
                    n_bm    = '0;
                    n_bs    = 1'b0;
                end
            end
            ST_PAIR: begin
                if (!pair_over) begin
                    if (pair_skip) begin
                        n_sign = adv_sign;
                        n_m    = adv_m;
                        n_mr   = adv_mr;
                    end else begin
                        n_value = r_sign ? r_mr + VAL_W'(1) : r_mr - VAL_W'(1);
                        n_dq    = DIV_W'(r_sign ? r_mr + VAL_W'(1) : r_mr - VAL_W'(1));
                        n_k     = r_klim;
                        n_rem   = '0;
                        n_step  = '0;
                    end
                end
            end
            ST_DIV: begin
                n_dq   = d_dq;
                n_rem  = d_rem;
                n_step = r_step + STEP_W'(1);
            end
            ST_EVAL: begin
                if (cand || (r_k == K_W'(2))) begin
                    if (cand && better) begin
                        n_found = 1'b1;
                        n_bk    = r_k;
                        n_bt    = r_dq[HALF_W-1:0];
                        n_bm    = r_m[M_W-1:0];
                        n_bs    = r_sign;
                    end
                    n_sign = adv_sign;
                    n_m    = adv_m;
                    n_mr   = adv_mr;
                end else begin
                    n_k    = r_k - K_W'(1);
                    n_dq   = DIV_W'(r_value);
                    n_rem  = '0;
                    n_step = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_r     <= n_r;
        r_half  <= n_half;
        r_klim  <= n_klim;
        r_m     <= n_m;
        r_mr    <= n_mr;
        r_sign  <= n_sign;
        r_value <= n_value;
        r_k     <= n_k;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_found <= n_found;
        r_bk    <= n_bk;
        r_bt    <= n_bt;
        r_bm    <= n_bm;
        r_bs    <= n_bs;
        if ((r_state == ST_FINISH) && out_free) begin
            r_out_data <= {5'b0, r_bs, r_bm, r_bt, r_bk};
            r_out_user <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_out_valid      <= 1'b0;
            r_max_multiplier <= K_W'(20);
            r_max_multiple   <= M_W'(12);
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_MULTIPLIER: r_max_multiplier <= i_cfg_data;
                    REG_MAX_MULTIPLE:   r_max_multiple   <= i_cfg_data[M_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `SCWS_ASSERT_NOW(a_div_range, r_state == ST_DIV || r_state == ST_EVAL,
        r_k >= K_W'(2) && r_k <= r_klim, "divisor outside scan range")
    `SCWS_ASSERT_NOW(a_rem_small, r_state == ST_EVAL, r_rem < r_k,
        "remainder not below divisor")
    `SCWS_ASSERT_NEXT(a_accept_start, in_accept, r_state == ST_PAIR,
        "item accepted without starting the scan")
    `SCWS_ASSERT_NOW(a_found_fields, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[5:0] >= 6'd2 && m_axis_tdata[41:37] != 5'd0,
        "found result with empty divisor or multiple")

endmodule

`default_nettype wire

// ===== dv/small_cofactor_witness_search_unit_tb.sv =====
// Self-checking testbench for small_cofactor_witness_search_unit.
// Predicts each witness from the modulus and the current limits and checks every result item.
// Depends on scws_pkg and on the unit's stream and register ports.
`default_nettype none

module small_cofactor_witness_search_unit_tb;
    import scws_pkg::*;

    localparam int IDLE_PCT      = 37;
    localparam int STALL_LIMIT   = 60000;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUO_LSB       = K_W;
    localparam int MUL_LSB       = K_W + HALF_W;
    localparam int SIGN_BIT      = K_W + HALF_W + M_W;
    localparam int FILL_LSB      = SIGN_BIT + 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef struct packed {
        logic              found;
        logic [K_W-1:0]    divisor;
        logic [HALF_W-1:0] quotient;
        logic [M_W-1:0]    multiple;
        logic              plus;
    } t_witness;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [K_W-1:0]       i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [R_W-1:0]       s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;

    logic [K_W-1:0] cfg_max_divisor = 6'd20;
    logic [M_W-1:0] cfg_max_multiple = 5'd12;
    t_witness       pending_witnesses[$];
    bit             no_idle = 1'b0;
    int             n_errors = 0;
    int             n_moduli = 0;
    int             n_results = 0;
    int             n_found = 0;
    int             n_writes = 0;
    int             n_settings = 0;
    int             stall_cycles = 0;

    small_cofactor_witness_search_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_witness find_witness(input logic [R_W-1:0] r,
                                              input logic [K_W-1:0] kcfg,
                                              input logic [M_W-1:0] mcfg);
        logic [63:0] half;
        logic [63:0] mr;
        logic [63:0] value;
        logic [63:0] t;
        int          klim;
        bit          hit;
        t_witness    best;
        half = 64'(r) >> 1;
        klim = (kcfg > K_LIMIT) ? K_LIMIT : int'(kcfg);
        best = '0;
        for (int m = 1; m <= int'(mcfg); m++) begin
            mr = 64'(m) * 64'(r);
            for (int s = 0; s < 2; s++) begin
                if (s == 1 || mr > 64'd1) begin
                    value = (s == 1) ? mr + 64'd1 : mr - 64'd1;
                    hit = 1'b0;
                    for (int k = klim; k >= 2; k--) begin
                        t = value / 64'(k);
                        if (!hit && value % 64'(k) == 64'd0 && t <= half) begin
                            hit = 1'b1;
                            if (!best.found || t < 64'(best.quotient) ||
                                (t == 64'(best.quotient) && k < int'(best.divisor))) begin
                                best.found    = 1'b1;
                                best.divisor  = K_W'(k);
                                best.quotient = HALF_W'(t);
                                best.multiple = M_W'(m);
                                best.plus     = (s == 1);
                            end
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    function automatic logic [R_W-1:0] pick_modulus();
        logic [R_W-1:0] r;
        case ($urandom_range(3))
            0: r = $urandom;
            1: r = $urandom_range(2000);
            2: r = 32'hFFFF_FFFF - $urandom_range(1000);
            default: r = $urandom >> $urandom_range(31);
        endcase
        return r;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : result_check
        t_witness want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_witnesses.size() == 0) begin
                $error("unexpected result item: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                want = pending_witnesses.pop_front();
                if (want.found) n_found++;
                if (m_axis_tuser !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata[K_W-1:0] !== want.divisor) begin
                    $error("best_divisor: expected %0d, got %0d", want.divisor,
                           m_axis_tdata[K_W-1:0]);
                    n_errors++;
                end
                if (m_axis_tdata[QUO_LSB +: HALF_W] !== want.quotient) begin
                    $error("best_quotient: expected %0d, got %0d", want.quotient,
                           m_axis_tdata[QUO_LSB +: HALF_W]);
                    n_errors++;
                end
                if (m_axis_tdata[MUL_LSB +: M_W] !== want.multiple) begin
                    $error("best_multiple: expected %0d, got %0d", want.multiple,
                           m_axis_tdata[MUL_LSB +: M_W]);
                    n_errors++;
                end
                if (m_axis_tdata[SIGN_BIT] !== want.plus) begin
                    $error("plus_sign: expected %0d, got %0d", want.plus, m_axis_tdata[SIGN_BIT]);
                    n_errors++;
                end
                if (m_axis_tdata[OUT_W-1:FILL_LSB] !== '0) begin
                    $error("zero_fill: expected 0, got %0h", m_axis_tdata[OUT_W-1:FILL_LSB]);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_modulus(input logic [R_W-1:0] r);
        t_witness predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = find_witness(r, cfg_max_divisor, cfg_max_multiple);
        pending_witnesses = {pending_witnesses, predicted};
        n_moduli++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_witnesses.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [K_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MAX_MULTIPLIER: cfg_max_divisor = data;
            REG_MAX_MULTIPLE:   cfg_max_multiple = data[M_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [K_W-1:0] kdata, input logic [K_W-1:0] mdata);
        write_register(REG_MAX_MULTIPLIER, kdata);
        write_register(REG_MAX_MULTIPLE, mdata);
        n_settings++;
    endtask

    task automatic test_reset_settings();
        send_modulus(32'd0);
        send_modulus(32'd1);
        send_modulus(32'd2);
        send_modulus(32'd3);
        send_modulus(32'hFFFF_FFFF);
        send_modulus(32'h8000_0000);
        send_modulus(32'd1000003);
        wait_idle();
    endtask

    task automatic test_divisor_limits();
        apply_settings(6'd0, 6'd12);
        send_modulus(32'd97);
        wait_idle();
        apply_settings(6'd1, 6'd12);
        send_modulus(32'd97);
        wait_idle();
        apply_settings(6'd2, 6'd12);
        send_modulus(32'd5);
        send_modulus(32'h7FFF_FFFF);
        wait_idle();
        apply_settings(6'd33, 6'd12);
        send_modulus(32'd65537);
        send_modulus(32'hFFFF_FFFE);
        wait_idle();
        apply_settings(6'h3F, 6'd12);
        send_modulus(32'd101);
        send_modulus(32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_multiple_limits();
        apply_settings(6'd20, 6'h20);
        send_modulus(32'd1009);
        wait_idle();
        apply_settings(6'd32, 6'd1);
        send_modulus(32'd3);
        send_modulus(32'hFFFF_FFFF);
        wait_idle();
        apply_settings(6'd32, 6'h3F);
        send_modulus(32'hFFFF_FFFE);
        wait_idle();
    endtask

    task automatic test_unused_index();
        apply_settings(6'd20, 6'd12);
        write_register(REG_UNUSED_2, 6'h3F);
        write_register(REG_UNUSED_3, 6'h00);
        send_modulus(32'd123457);
        wait_idle();
    endtask

    // Small limits keep most items short; a fifth of the settings use any divisor limit.
    task automatic test_random_phases();
        logic [K_W-1:0] kdata;
        logic [K_W-1:0] mdata;
        for (int phase = 0; phase < 40; phase++) begin
            no_idle = (phase >= 12 && phase < 18);
            kdata = ($urandom_range(4) == 0) ? K_W'($urandom_range(63))
                                             : K_W'($urandom_range(2, 14));
            mdata = {1'($urandom_range(1)),
                     ($urandom_range(9) == 0) ? 5'd0 : 5'($urandom_range(1, 4))};
            apply_settings(kdata, mdata);
            repeat (40) send_modulus(pick_modulus());
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_wide_settings();
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                apply_settings(6'h3F, 6'h1F);
            end else begin
                apply_settings(K_W'($urandom_range(24, 63)),
                               {1'($urandom_range(1)), 5'($urandom_range(20, 31))});
            end
            repeat (3) send_modulus(pick_modulus());
            wait_idle();
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_settings();
        test_divisor_limits();
        test_multiple_limits();
        test_unused_index();
        test_random_phases();
        test_wide_settings();
        if (pending_witnesses.size() != 0) begin
            $error("%0d expected result items never arrived", pending_witnesses.size());
            n_errors++;
        end
        $display("Run covered %0d moduli and %0d results, %0d of them with a witness.",
                 n_moduli, n_results, n_found);
        $display("Limits changed through %0d settings with %0d register writes.",
                 n_settings, n_writes);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== small_cofactor_witness_search_unit.f =====
+incdir+src
src/scws_pkg.sv
src/small_cofactor_witness_search_unit.sv
dv/small_cofactor_witness_search_unit_tb.sv
